// File: rtl/core/lbf_pkg.sv
// Shared types, sizes and helpers of the 3x3 diagonal filter.
`default_nettype none
package lbf_pkg;

	localparam int IMG_WIDTH  = 512;
	localparam int IMG_HEIGHT = 512;
	localparam int TOTAL      = IMG_WIDTH * IMG_HEIGHT;

	localparam int PIX_W   = 16;
	localparam int VAL_W   = 20;
	localparam int COL_W   = $clog2(IMG_WIDTH);
	localparam int ROW_W   = $clog2(IMG_HEIGHT);
	localparam int TAKEN_W = $clog2(TOTAL + 1);
	localparam int LINE_W  = 2 * PIX_W;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef logic signed [PIX_W-1:0] pix_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [COL_W-1:0]        col_t;
	typedef logic [ROW_W-1:0]        row_t;
	typedef logic [TAKEN_W-1:0]      taken_t;

	// one window column: [0] top row, [1] middle row, [2] bottom row
	typedef pix_t [2:0] tap_col_t;

	// output position and end-of-frame mark that travel with an item
	typedef struct packed {
		row_t row;
		col_t col;
		logic last;
	} pos_t;

	function automatic val_t sx(input pix_t p);
		return {{(VAL_W-PIX_W){p[PIX_W-1]}}, p};
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/lbf_in_if.sv
// Input channel: pixel or flush items with valid/ready handshake.
`default_nettype none
interface lbf_in_if;
	import lbf_pkg::*;

	logic valid;
	logic ready;
	logic cmd;
	pix_t pixel;

	modport source(output valid, output cmd, output pixel, input ready);
	modport sink(input valid, input cmd, input pixel, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lbf_out_if.sv
// Output channel: filtered values with end-of-frame mark.
`default_nettype none
interface lbf_out_if;
	import lbf_pkg::*;

	logic valid;
	logic ready;
	val_t value;
	logic last;

	modport source(output valid, output value, output last, input ready);
	modport sink(input valid, input value, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lbf_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule
`default_nettype wire

// File: rtl/core/lbf_cell.sv
// One window column cell: holds three taps, hands them to its left neighbor.
`default_nettype none
module lbf_cell (
	input  wire logic              clk,
	input  wire logic              shift,
	input  wire lbf_pkg::tap_col_t taps_in,
	output lbf_pkg::tap_col_t      taps_out
);
	import lbf_pkg::*;

	tap_col_t taps_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			taps_q <= taps_in;
		end
	end

	assign taps_out = taps_q;
endmodule
`default_nettype wire

// File: rtl/core/line_buffered_3x3_diagonal_filter.sv
// Top level of the line-buffered 3x3 diagonal-weighted filter.
//
// Pixels of a raster-order frame (lbf_pkg::IMG_WIDTH x IMG_HEIGHT) enter one item per
// clock unless the output stalls; each output is the sum over in-frame neighbors of
// pixel * (dy + dx), with taps outside the frame masked. Results lag the input by
// IMG_WIDTH+1 pixels, so after the last pixel the source sends IMG_WIDTH+1 flush items
// (cmd=1) to drain the frame; a flush before the frame is complete and a pixel beyond it
// are consumed and give no result. The final output of a frame has last set, after which
// a new frame may start. Sustained rate, with no output back-pressure, is one item per
// cycle, limited by the single read and single write port of the line store RAM
// (IMG_WIDTH words of two pixels). A result passes through the RAM read at the edge that
// accepts its item, the window shift through the row of three column cells, then the
// weighted sum into the output register. The line store is not cleared after reset; any
// stale tap it supplies falls outside the frame.
`default_nettype none
module line_buffered_3x3_diagonal_filter (
	input wire logic  clk,
	input wire logic  arst_n,
	lbf_in_if.sink    stream,
	lbf_out_if.source filtered
);
	import lbf_pkg::*;

	// front control
	taken_t taken_q;
	col_t   in_col_q;
	row_t   out_row_q;
	col_t   out_col_q;

	logic accept, is_flush, frame_full, do_shift, do_emit, last_now;
	col_t rd_col;
	pos_t pos_now;

	// stage 1: RAM read pending
	logic valid_s1;
	pix_t pix_s1;
	col_t col_s1;
	logic emit_s1;
	pos_t pos_s1;

	// stage 2: window holds the item's neighborhood
	logic valid_s2;
	pos_t pos_s2;

	// output register
	logic out_valid_q;
	val_t value_q;
	logic last_q;

	logic free1, free2, free3, adv12;
	logic [LINE_W-1:0] rd_line;
	tap_col_t cell_in;
	tap_col_t win [3];
	logic row_lo_ok, row_hi_ok, col_lo_ok, col_hi_ok;
	val_t sum;

	assign free3 = !out_valid_q || filtered.ready;
	assign free2 = !valid_s2 || free3;
	assign free1 = !valid_s1 || free2;
	assign adv12 = valid_s1 && free2;

	assign stream.ready = free1;
	assign accept       = stream.valid && free1;
	assign is_flush     = (stream.cmd == CMD_FLUSH);
	assign frame_full   = (taken_q >= TAKEN_W'(TOTAL));
	assign do_shift     = accept && (is_flush ? frame_full : !frame_full);
	assign do_emit      = accept && (is_flush ? frame_full
	                                          : (!frame_full && taken_q >= TAKEN_W'(IMG_WIDTH + 1)));
	assign last_now     = (out_row_q == ROW_W'(IMG_HEIGHT - 1)) &&
	                      (out_col_q == COL_W'(IMG_WIDTH - 1));

	always_comb begin
		if (is_flush) begin
			rd_col = (out_col_q == COL_W'(IMG_WIDTH - 1)) ? '0 : out_col_q + COL_W'(1);
		end else begin
			rd_col = in_col_q;
		end
		pos_now.row  = out_row_q;
		pos_now.col  = out_col_q;
		pos_now.last = last_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q   <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else begin
			if (do_shift && !is_flush) begin
				taken_q  <= taken_q + TAKEN_W'(1);
				in_col_q <= (in_col_q == COL_W'(IMG_WIDTH - 1)) ? '0 : in_col_q + COL_W'(1);
			end
			if (do_emit) begin
				if (last_now) begin
					// frame done: restart all counters
					taken_q   <= '0;
					in_col_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
				end else if (out_col_q == COL_W'(IMG_WIDTH - 1)) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free1) begin
				valid_s1 <= do_shift;
			end
			if (free2) begin
				valid_s2 <= valid_s1 && emit_s1;
			end
			if (free3) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (free1 && do_shift) begin
			pix_s1  <= is_flush ? '0 : stream.pixel;
			col_s1  <= rd_col;
			emit_s1 <= do_emit;
			pos_s1  <= pos_now;
		end
		if (adv12) begin
			pos_s2 <= pos_s1;
		end
		if (free3 && valid_s2) begin
			value_q <= sum;
			last_q  <= pos_s2.last;
		end
	end

	// line store: upper half is the older line, lower half the newer line
	lbf_ram #(
		.WIDTH(LINE_W),
		.DEPTH(IMG_WIDTH)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (adv12),
		.wr_addr(col_s1),
		.wr_data({rd_line[PIX_W-1:0], pix_s1}),
		.rd_en  (do_shift),
		.rd_addr(rd_col),
		.rd_data(rd_line)
	);

	assign cell_in[0] = rd_line[LINE_W-1:PIX_W];
	assign cell_in[1] = rd_line[PIX_W-1:0];
	assign cell_in[2] = pix_s1;

	// window: cell 2 takes the new column, cell 0 holds the leftmost
	lbf_cell u_cell2 (.clk(clk), .shift(adv12), .taps_in(cell_in), .taps_out(win[2]));
	lbf_cell u_cell1 (.clk(clk), .shift(adv12), .taps_in(win[2]),  .taps_out(win[1]));
	lbf_cell u_cell0 (.clk(clk), .shift(adv12), .taps_in(win[1]),  .taps_out(win[0]));

	always_comb begin
		row_lo_ok = (pos_s2.row != '0);
		row_hi_ok = (pos_s2.row != ROW_W'(IMG_HEIGHT - 1));
		col_lo_ok = (pos_s2.col != '0);
		col_hi_ok = (pos_s2.col != COL_W'(IMG_WIDTH - 1));
		// weight dy+dx: zero on the anti-diagonal, masked taps drop out
		sum = '0;
		if (row_lo_ok && col_lo_ok) begin
			sum = sum - (sx(win[0][0]) <<< 1);
		end
		if (col_lo_ok) begin
			sum = sum - sx(win[0][1]);
		end
		if (row_lo_ok) begin
			sum = sum - sx(win[1][0]);
		end
		if (row_hi_ok) begin
			sum = sum + sx(win[1][2]);
		end
		if (col_hi_ok) begin
			sum = sum + sx(win[2][1]);
		end
		if (row_hi_ok && col_hi_ok) begin
			sum = sum + (sx(win[2][2]) <<< 1);
		end
	end

	assign filtered.valid = out_valid_q;
	assign filtered.value = value_q;
	assign filtered.last  = last_q;
endmodule
`default_nettype wire

// File: rtl/core/lbf_checker.sv
// Port-level assertions for the diagonal filter, bound to the top level.
`default_nettype none
module lbf_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          stream_ready,
	input wire logic          filt_valid,
	input wire logic          filt_ready,
	input wire lbf_pkg::val_t filt_value,
	input wire logic          filt_last
);
	import lbf_pkg::*;

	// a stalled result holds
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		filt_valid && !filt_ready |=> filt_valid)
		else $error("result dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		filt_valid && !filt_ready |=> $stable(filt_value) && $stable(filt_last))
		else $error("result changed while stalled");

	// input backs up only behind a blocked output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!stream_ready |-> filt_valid && !filt_ready)
		else $error("input stalled without output back-pressure");

	// a new frame needs IMG_WIDTH+1 pixels before its first result
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		filt_valid && filt_ready && filt_last |=> !filt_valid)
		else $error("result right after end of frame");
endmodule

bind line_buffered_3x3_diagonal_filter lbf_checker u_lbf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.stream_ready(stream.ready),
	.filt_valid  (filtered.valid),
	.filt_ready  (filtered.ready),
	.filt_value  (filtered.value),
	.filt_last   (filtered.last)
);
`default_nettype wire
